// ===== sv/assert_macros.svh =====
// assertion macros shared by the console engine rtl
// no dependencies; compiled to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/tce_pkg.sv =====
// types and constants of the text console engine
// used by tce_front, tce_back and text_console_engine
`default_nettype none
package tce_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int QUEUE_DEPTH = 4;
    localparam int TAB_STOP    = 4;
    localparam int TAB_W       = $clog2(TAB_STOP);

    localparam logic [7:0] ATTR_RESET  = 8'd31;
    localparam logic [6:0] GUARD_RESET = 7'd4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD     = 2'd1;

    localparam logic [2:0] ACT_PRINT = 3'd0;
    localparam logic [2:0] ACT_PUT   = 3'd1;
    localparam logic [2:0] ACT_SET   = 3'd2;
    localparam logic [2:0] ACT_LEFT  = 3'd3;
    localparam logic [2:0] ACT_RIGHT = 3'd4;
    localparam logic [2:0] ACT_CLEAR = 3'd5;
    localparam logic [2:0] ACT_READ  = 3'd6;
    localparam logic [2:0] ACT_SPARE = 3'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [3:0] {
        OP_NEWLINE,
        OP_CR,
        OP_BS,
        OP_TAB,
        OP_CHAR,
        OP_PUT,
        OP_SET,
        OP_LEFT,
        OP_RIGHT,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_code;
        logic [6:0] col_in;
        logic [4:0] row_in;
    } in_t;

    typedef struct packed {
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_pos;
        logic        rejected;
    } out_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
        logic       in_bounds;
    } cmd_t;

endpackage
`default_nettype wire

// ===== sv/tce_front.sv =====
// front end: accepts words, classifies them and queues decoded commands
// depends on tce_pkg
`default_nettype none
module tce_front #(
    parameter int COLUMNS = tce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tce_pkg::ROWS_DEF,
    parameter int DEPTH   = tce_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire tce_pkg::in_t request,
    output logic              cmd_valid,
    output tce_pkg::cmd_t     cmd,
    input  wire logic         cmd_take
);
    import tce_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          q_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [NW-1:0] count_reg;
    cmd_t          dec;
    logic          do_push, do_pop;

    always_comb
    begin
        dec.ch        = request.char_code;
        dec.col       = request.col_in;
        dec.row       = request.row_in;
        dec.in_bounds = (request.col_in < COLUMNS) && (request.row_in < ROWS);
        unique case (request.action)
            ACT_PRINT:
            begin
                unique case (request.char_code)
                    CH_NL:   dec.op = OP_NEWLINE;
                    CH_CR:   dec.op = OP_CR;
                    CH_BS:   dec.op = OP_BS;
                    CH_TAB:  dec.op = OP_TAB;
                    default: dec.op = OP_CHAR;
                endcase
            end
            ACT_PUT:   dec.op = OP_PUT;
            ACT_SET:   dec.op = OP_SET;
            ACT_LEFT:  dec.op = OP_LEFT;
            ACT_RIGHT: dec.op = OP_RIGHT;
            ACT_CLEAR: dec.op = OP_CLEAR;
            ACT_READ:  dec.op = OP_READ;
            default:   dec.op = OP_NOP;
        endcase
    end

    assign full      = (count_reg == NW'(DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/tce_back.sv =====
// back end: cursor state, screen store and the sweeps for scroll, tab and clear
// depends on tce_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module tce_back #(
    parameter int COLUMNS = tce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tce_pkg::ROWS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire tce_pkg::cmd_t cmd,
    output logic               cmd_take,
    input  wire logic [7:0]    attribute,
    input  wire logic [6:0]    guard,
    output logic               empty,
    input  wire logic          pop,
    output tce_pkg::out_t      response
);
    import tce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int RW    = $clog2(ROWS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCROLL,
        S_TAB,
        S_CHAR,
        S_CLEAR,
        S_READ,
        S_DONE
    } state_t;

    state_t        state_reg, state_next, post_reg, post_next, nl_post;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next, top_reg, top_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    cmd_t          cmd_reg, cmd_next;
    logic [7:0]    rd_char_reg, rd_char_next, rd_attr_reg, rd_attr_next;
    logic          rej_reg, rej_next;
    out_t          out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    logic          do_nl;

    logic [15:0]   mem [CELLS];
    logic [15:0]   rdata_reg;
    logic          we, use_lin;
    logic [RW-1:0] wrow;
    logic [CW-1:0] wcol;
    logic [7:0]    wch;
    logic [AW-1:0] waddr, raddr;

    // screen row to physical address through the scroll ring
    function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c,
                                              input logic [RW-1:0] top);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, top};
        if (s >= (RW+1)'(ROWS))
        begin
            s = s - (RW+1)'(ROWS);
        end
        return AW'(s * COLUMNS) + AW'(c);
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        post_next      = post_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        sweep_next     = sweep_reg;
        cmd_next       = cmd_reg;
        rd_char_next   = rd_char_reg;
        rd_attr_next   = rd_attr_reg;
        rej_next       = rej_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cmd_take       = 1'b0;
        we             = 1'b0;
        use_lin        = 1'b0;
        wrow           = row_reg;
        wcol           = col_reg;
        wch            = CH_SPACE;
        do_nl          = 1'b0;
        nl_post        = S_DONE;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_take     = 1'b1;
                    cmd_next     = cmd;
                    rd_char_next = '0;
                    rd_attr_next = '0;
                    rej_next     = 1'b0;
                    state_next   = S_DONE;
                    unique case (cmd.op)
                        OP_NEWLINE:
                        begin
                            do_nl = 1'b1;
                        end
                        OP_CR:
                        begin
                            col_next = '0;
                        end
                        OP_BS:
                        begin
                            if (col_reg == guard && col_reg < COLUMNS)
                            begin
                                col_next = col_reg + 1'b1;
                                if (col_reg < COLUMNS - 1)
                                begin
                                    we   = 1'b1;
                                    wcol = col_reg + 1'b1;
                                end
                            end
                            else if (col_reg == '0)
                            begin
                                if (row_reg != '0)
                                begin
                                    row_next = row_reg - 1'b1;
                                    col_next = CW'(COLUMNS - 1);
                                    we       = 1'b1;
                                    wrow     = row_reg - 1'b1;
                                    wcol     = CW'(COLUMNS - 1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg - 1'b1;
                                we       = 1'b1;
                                wcol     = col_reg - 1'b1;
                            end
                        end
                        OP_TAB:
                        begin
                            if (col_reg >= COLUMNS)
                            begin
                                do_nl   = 1'b1;
                                nl_post = S_TAB;
                            end
                            else
                            begin
                                state_next = S_TAB;
                            end
                        end
                        OP_CHAR:
                        begin
                            if (col_reg >= COLUMNS)
                            begin
                                do_nl   = 1'b1;
                                nl_post = S_CHAR;
                            end
                            else
                            begin
                                we       = 1'b1;
                                wch      = cmd.ch;
                                col_next = col_reg + 1'b1;
                            end
                        end
                        OP_PUT:
                        begin
                            if (cmd.in_bounds)
                            begin
                                we   = 1'b1;
                                wch  = cmd.ch;
                                wrow = RW'(cmd.row);
                                wcol = CW'(cmd.col);
                            end
                            else
                            begin
                                rej_next = 1'b1;
                            end
                        end
                        OP_SET:
                        begin
                            if (cmd.in_bounds)
                            begin
                                col_next = CW'(cmd.col);
                                row_next = RW'(cmd.row);
                            end
                            else
                            begin
                                rej_next = 1'b1;
                            end
                        end
                        OP_LEFT:
                        begin
                            if (col_reg != '0)
                            begin
                                if (col_reg > COLUMNS - 1)
                                begin
                                    col_next = CW'(COLUMNS - 1);
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                            else if (row_reg != '0)
                            begin
                                row_next = row_reg - 1'b1;
                                col_next = CW'(COLUMNS - 1);
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (col_reg < COLUMNS - 1)
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            else if (row_reg < ROWS - 1)
                            begin
                                row_next = row_reg + 1'b1;
                                col_next = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            top_next   = '0;
                            row_next   = '0;
                            col_next   = '0;
                            sweep_next = '0;
                            state_next = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            if (cmd.in_bounds)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                rej_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCROLL:
            begin
                we         = 1'b1;
                wrow       = RW'(ROWS - 1);
                wcol       = CW'(sweep_reg);
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(COLUMNS - 1))
                begin
                    state_next = post_reg;
                end
            end
            S_TAB:
            begin
                we       = 1'b1;
                col_next = col_reg + 1'b1;
                if (col_reg[TAB_W-1:0] == TAB_W'(TAB_STOP - 1) || col_reg >= COLUMNS - 1)
                begin
                    state_next = S_DONE;
                end
            end
            S_CHAR:
            begin
                we         = 1'b1;
                wch        = cmd_reg.ch;
                col_next   = col_reg + 1'b1;
                state_next = S_DONE;
            end
            S_CLEAR:
            begin
                we         = 1'b1;
                use_lin    = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                rd_char_next = rdata_reg[7:0];
                rd_attr_next = rdata_reg[15:8];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next      = 1'b1;
                out_next.read_char  = rd_char_reg;
                out_next.read_attr  = rd_attr_reg;
                out_next.cursor_col = 7'(col_reg);
                out_next.cursor_row = 5'(row_reg);
                out_next.cursor_pos = 11'(row_reg * COLUMNS + col_reg);
                out_next.rejected   = rej_reg;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // new line: next row, or scroll the ring and blank the bottom row
        if (do_nl)
        begin
            col_next = '0;
            if (row_reg < ROWS - 1)
            begin
                row_next   = row_reg + 1'b1;
                state_next = nl_post;
            end
            else
            begin
                top_next   = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                sweep_next = '0;
                post_next  = nl_post;
                state_next = S_SCROLL;
            end
        end
    end

    assign waddr    = use_lin ? sweep_reg : addr_of(wrow, wcol, top_reg);
    assign raddr    = addr_of(RW'(cmd.row), CW'(cmd.col), top_reg);
    assign empty    = !out_valid_reg;
    assign response = out_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {attribute, wch};
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            post_reg      <= S_DONE;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            post_reg      <= post_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        rd_char_reg <= rd_char_next;
        rd_attr_reg <= rd_attr_next;
        rej_reg     <= rej_next;
        out_reg     <= out_next;
    end

    `TCE_ASSERT_IMP(a_col_range, clk, rst_n, 1'b1, col_reg <= COLUMNS)
    `TCE_ASSERT_IMP(a_ring_range, clk, rst_n, 1'b1, row_reg < ROWS && top_reg < ROWS)
    `TCE_ASSERT_IMP(a_done_slot_free, clk, rst_n, state_reg == S_DONE, !out_valid_reg)
    `TCE_ASSERT_NXT(a_take_only_idle, clk, rst_n, cmd_take, state_reg != S_IDLE || !empty)

endmodule
`default_nettype wire

// ===== sv/text_console_engine.sv =====
// top level of the text console engine: config registers, front and back end
// depends on tce_pkg, tce_front and tce_back
//
// channel   direction  handshake          payload
// request   in         push / full        in_t: action, char_code, col_in, row_in
// response  out        pop / empty        out_t: read, cursor and rejected fields
// config    in         cfg_valid / ready  cfg_index, cfg_data
//
// cursor moves, put-at and set-cursor go from S_IDLE to S_DONE, a read via S_READ
// a character or tab at the right edge takes a new line first, a tab fills in S_TAB;
// a scrolling new line blanks the bottom row in S_SCROLL, one cell a cycle
// clear sweeps the screen in S_CLEAR, one screen cell written per cycle
// a 4-deep command queue keeps taking words while the back end works or a result waits
// reset restores cursor, scroll ring, queue and config; the screen is undefined until written
`default_nettype none
module text_console_engine #(
    parameter int COLUMNS = tce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tce_pkg::ROWS_DEF,
    parameter int DEPTH   = tce_pkg::QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire tce_pkg::in_t                    request,
    output logic                                 empty,
    input  wire logic                            pop,
    output tce_pkg::out_t                        response,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import tce_pkg::*;

    logic [7:0] attr_reg;
    logic [6:0] guard_reg;
    logic       cmd_valid, cmd_take;
    cmd_t       cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= ATTR_RESET;
            guard_reg <= GUARD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ATTRIBUTE: attr_reg  <= cfg_data;
                CFG_GUARD:     guard_reg <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    tce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .DEPTH   (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .attribute (attr_reg),
        .guard     (guard_reg),
        .empty     (empty),
        .pop       (pop),
        .response  (response)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_text_console_engine.sv =====
`timescale 1ns / 1ps
// self-checking testbench for text_console_engine: a screen predictor checks every result
// depends on tce_pkg and the text_console_engine rtl
`default_nettype none
module tb_text_console_engine;
    import tce_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_t  request;
    logic empty;
    logic pop;
    out_t response;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    text_console_engine uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .request(request),
        .empty(empty), .pop(pop), .response(response), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predicted console state
    logic [15:0] screen [COLS*ROWS];
    int top_row;
    int cur_col;
    int cur_row;
    logic [7:0] attr_reg;
    int guard_col;

    in_t  feed_q[$];
    out_t result_q[$];
    bit   idle_on;
    int   errors;
    int   words_in;
    int   words_out;
    int   reads_seen;
    int   rejects_seen;
    int   cycles;
    int   push_gap;
    int   pop_gap;

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic void put_cell(int r, int c, logic [7:0] ch);
        if (r < ROWS && c < COLS)
            screen[((r + top_row) % ROWS) * COLS + c] = {attr_reg, ch};
    endfunction

    function automatic void take_new_line();
        if (cur_row < ROWS - 1)
            cur_row++;
        else
        begin
            top_row = (top_row + 1) % ROWS;
            for (int x = 0; x < COLS; x++)
                put_cell(ROWS - 1, x, CH_SPACE);
        end
        cur_col = 0;
    endfunction

    function automatic void print_char(logic [7:0] c);
        int n;
        case (c)
            CH_NL: take_new_line();
            CH_CR: cur_col = 0;
            CH_BS:
            begin
                if (cur_col == guard_col && cur_col < COLS)
                begin
                    cur_col++;
                    put_cell(cur_row, cur_col, CH_SPACE);
                end
                else if (!(cur_col == 0 && cur_row == 0))
                begin
                    if (cur_col == 0)
                    begin
                        cur_row--;
                        cur_col = COLS;
                    end
                    cur_col--;
                    put_cell(cur_row, cur_col, CH_SPACE);
                end
            end
            CH_TAB:
            begin
                if (cur_col >= COLS)
                    take_new_line();
                n = TAB_STOP - (cur_col % TAB_STOP);
                while (n != 0 && cur_col < COLS)
                begin
                    put_cell(cur_row, cur_col, CH_SPACE);
                    cur_col++;
                    n--;
                end
            end
            default:
            begin
                if (cur_col >= COLS)
                    take_new_line();
                put_cell(cur_row, cur_col, c);
                cur_col++;
            end
        endcase
    endfunction

    function automatic out_t console_step(in_t w);
        out_t r;
        bit on_screen;
        logic [15:0] v;
        r = '0;
        on_screen = w.col_in < COLS && w.row_in < ROWS;
        case (w.action)
            ACT_PRINT: print_char(w.char_code);
            ACT_PUT:
                if (on_screen) put_cell(w.row_in, w.col_in, w.char_code);
                else r.rejected = 1'b1;
            ACT_SET:
                if (on_screen)
                begin
                    cur_col = w.col_in;
                    cur_row = w.row_in;
                end
                else r.rejected = 1'b1;
            ACT_LEFT:
                if (cur_col > 0)
                    cur_col = (cur_col > COLS - 1) ? COLS - 1 : cur_col - 1;
                else if (cur_row > 0)
                begin
                    cur_row--;
                    cur_col = COLS - 1;
                end
            ACT_RIGHT:
                if (cur_col < COLS - 1)
                    cur_col++;
                else if (cur_row < ROWS - 1)
                begin
                    cur_row++;
                    cur_col = 0;
                end
            ACT_CLEAR:
            begin
                top_row = 0;
                cur_col = 0;
                cur_row = 0;
                for (int i = 0; i < COLS * ROWS; i++)
                    screen[i] = {attr_reg, CH_SPACE};
            end
            ACT_READ:
                if (on_screen)
                begin
                    v = screen[((w.row_in + top_row) % ROWS) * COLS + w.col_in];
                    r.read_char = v[7:0];
                    r.read_attr = v[15:8];
                end
                else r.rejected = 1'b1;
            default: ;
        endcase
        r.cursor_col = cur_col[6:0];
        r.cursor_row = cur_row[4:0];
        r.cursor_pos = 11'(cur_row * COLS + cur_col);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // driver: takes words from the feed queue and predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            request <= '0;
            push_gap = 0;
        end
        else
        begin
            if (push && !full)
            begin
                result_q.push_back(console_step(request));
                words_in++;
            end
            if (!push || !full)
            begin
                if (push_gap > 0)
                begin
                    push_gap--;
                    push <= 1'b0;
                end
                else if (feed_q.size() > 0)
                begin
                    request <= feed_q.pop_front();
                    push <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        push_gap = $urandom_range(1, 4);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: pops results with random stalls while idle_on is set and checks them in order
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                words_out++;
                if (result_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result word %h", $time, response);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want.read_char != 0 || want.read_attr != 0) reads_seen++;
                    if (want.rejected) rejects_seen++;
                    check_field("read_char", want.read_char, response.read_char);
                    check_field("read_attr", want.read_attr, response.read_attr);
                    check_field("cursor_col", want.cursor_col, response.cursor_col);
                    check_field("cursor_row", want.cursor_row, response.cursor_row);
                    check_field("cursor_pos", want.cursor_pos, response.cursor_pos);
                    check_field("rejected", want.rejected, response.rejected);
                end
            end
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    pop_gap = $urandom_range(1, 4);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic in_t make_word(logic [2:0] act, logic [7:0] ch, int c, int r);
        in_t w;
        w.action = act;
        w.char_code = ch;
        w.col_in = c[6:0];
        w.row_in = r[4:0];
        return w;
    endfunction

    function automatic in_t random_word();
        int pick;
        int c;
        int r;
        logic [7:0] ch;
        pick = $urandom_range(0, 199);
        c = $urandom_range(0, COLS - 1);
        r = $urandom_range(0, ROWS - 1);
        if ($urandom_range(0, 11) == 0)
        begin
            c = $urandom_range(0, 127);
            r = $urandom_range(0, 31);
        end
        case ($urandom_range(0, 9))
            0: ch = CH_NL;
            1: ch = CH_BS;
            2: ch = CH_TAB;
            3: ch = CH_CR;
            4: ch = 8'($urandom_range(0, 255));
            default: ch = 8'($urandom_range(8'h21, 8'h7e));
        endcase
        if (pick < 100) return make_word(ACT_PRINT, ch, c, r);
        if (pick < 118) return make_word(ACT_PUT, ch, c, r);
        if (pick < 135) return make_word(ACT_SET, ch, c, r);
        if (pick < 147) return make_word(ACT_LEFT, ch, c, r);
        if (pick < 159) return make_word(ACT_RIGHT, ch, c, r);
        if (pick < 161) return make_word(ACT_CLEAR, ch, c, r);
        if (pick < 196) return make_word(ACT_READ, ch, c, r);
        return make_word(ACT_SPARE, ch, c, r);
    endfunction

    task automatic drain();
        while (feed_q.size() > 0 || push || result_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_ATTRIBUTE) attr_reg = data;
        else guard_col = data[6:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int count, logic [7:0] attr, logic [7:0] guard);
        drain();
        write_reg(CFG_ATTRIBUTE, attr);
        write_reg(CFG_GUARD, guard);
        // park the cursor at the guard column, or the last column past it, now and then to reach that backspace rule
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                feed_q.push_back(make_word(ACT_SET, 8'h00,
                    guard < COLS ? guard : COLS - 1, $urandom_range(0, ROWS - 1)));
                feed_q.push_back(make_word(ACT_PRINT, CH_BS, 0, 0));
            end
            feed_q.push_back(random_word());
        end
    endtask

    initial
    begin
        errors = 0;
        words_in = 0;
        words_out = 0;
        reads_seen = 0;
        rejects_seen = 0;
        cycles = 0;
        idle_on = 1;
        top_row = 0;
        cur_col = 0;
        cur_row = 0;
        attr_reg = ATTR_RESET;
        guard_col = GUARD_RESET;
        for (int i = 0; i < COLS * ROWS; i++)
            screen[i] = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: clear first so no cell is ever read before it is written
        feed_q.push_back(make_word(ACT_CLEAR, 8'h00, 0, 0));
        feed_q.push_back(make_word(ACT_PRINT, CH_BS, 0, 0));
        feed_q.push_back(make_word(ACT_LEFT, 8'h00, 0, 0));
        feed_q.push_back(make_word(ACT_SET, 8'h00, 4, 0));
        feed_q.push_back(make_word(ACT_PRINT, CH_BS, 0, 0));
        feed_q.push_back(make_word(ACT_SET, 8'h00, 79, 0));
        feed_q.push_back(make_word(ACT_PRINT, 8'hff, 0, 0));
        feed_q.push_back(make_word(ACT_LEFT, 8'h00, 0, 0));
        feed_q.push_back(make_word(ACT_PRINT, 8'h41, 0, 0));
        feed_q.push_back(make_word(ACT_PRINT, CH_BS, 0, 0));
        feed_q.push_back(make_word(ACT_PRINT, 8'h42, 0, 0));
        feed_q.push_back(make_word(ACT_PRINT, CH_TAB, 0, 0));
        feed_q.push_back(make_word(ACT_SET, 8'h00, 0, 5));
        feed_q.push_back(make_word(ACT_PRINT, CH_BS, 0, 0));
        feed_q.push_back(make_word(ACT_SET, 8'h00, 79, 24));
        feed_q.push_back(make_word(ACT_RIGHT, 8'h00, 0, 0));
        feed_q.push_back(make_word(ACT_PRINT, CH_NL, 0, 0));
        feed_q.push_back(make_word(ACT_PRINT, CH_CR, 0, 0));
        feed_q.push_back(make_word(ACT_PUT, 8'h00, 127, 31));
        feed_q.push_back(make_word(ACT_SET, 8'h00, 80, 24));
        feed_q.push_back(make_word(ACT_READ, 8'h00, 0, 25));
        feed_q.push_back(make_word(ACT_PUT, 8'hff, 79, 24));
        feed_q.push_back(make_word(ACT_READ, 8'h00, 79, 24));
        feed_q.push_back(make_word(ACT_READ, 8'h00, 79, 0));
        feed_q.push_back(make_word(ACT_SPARE, 8'hff, 127, 31));

        random_phase(400, 8'h00, 8'd0);
        random_phase(400, 8'hff, 8'd80);
        random_phase(400, 8'($urandom_range(0, 255)), 8'd79);
        drain();
        idle_on = 0;
        random_phase(400, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 80)));
        drain();
        repeat (100) @(posedge clk);

        $display("%0d request words, %0d result words, %0d nonzero reads, %0d rejects",
                 words_in, words_out, reads_seen, rejects_seen);
        $display("register settings covered attribute 0 and 255, guard column 0, 79 and 80");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
